// ----- hdl/eglsc_pkg.sv -----
// Package for the epoch-guarded LRU set cache.
// Holds the stored entry layout, state codes, register index and reset values.
// No dependencies.
package eglsc_pkg;

  localparam int unsigned CAPACITY_DEF = 64;
  localparam logic [6:0]  BUDGET_RESET = 7'd32;

  typedef enum logic {
    REG_BUDGET = 1'b0,
    REG_NONE   = 1'b1
  } reg_idx_e;

  typedef struct packed {
    logic        valid;
    logic [31:0] layout;
    logic [7:0]  set;
    logic [1:0]  flags;
    logic [63:0] hash;
    logic [31:0] epoch;
    logic [63:0] age;
  } entry_t;

  typedef enum logic [6:0] {
    S_CLEAR  = 7'b0000001,
    S_IDLE   = 7'b0000010,
    S_MATCH  = 7'b0000100,
    S_EVCHK  = 7'b0001000,
    S_EVSCAN = 7'b0010000,
    S_FREE   = 7'b0100000,
    S_GUARD  = 7'b1000000
  } state_e;

endpackage

// ----- hdl/epoch_guarded_lru_set_cache.sv -----
// Epoch-guarded LRU set cache, top level. Uses eglsc_pkg.
// A lookup runs a match scan and an eviction check; each eviction adds an eviction scan and
// a check, and a scan that evicts nothing ends them. A miss then runs a free-slot scan. A
// guard scan (alone for device-idle) ends each transaction with the result strobe; the next
// is taken in the strobe cycle. Rate is set by the entry memory (one read, one write port)
// scanned one slot a cycle; the receiver cannot stall. After reset a clearing pass runs with busy high.
module epoch_guarded_lru_set_cache #(
  parameter int unsigned CAPACITY = eglsc_pkg::CAPACITY_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        start,
  output logic        busy,
  input  logic        action_i,
  input  logic [31:0] layout_id_i,
  input  logic [7:0]  set_number_i,
  input  logic        dynamic_uniform_i,
  input  logic        dynamic_storage_i,
  input  logic [63:0] content_hash_i,
  input  logic [31:0] newest_epoch_i,
  input  logic [31:0] completed_epoch_i,
  output logic        result_valid_o,
  output logic        hit_o,
  output logic [5:0]  slot_o,
  output logic        table_full_o,
  output logic [6:0]  evicted_count_o,
  output logic [6:0]  resident_count_o,
  output logic [6:0]  guarded_count_o
);

  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned KW = (CW > 7) ? CW : 7;
  localparam logic [CW-1:0] CAP = CW'(CAPACITY);

  eglsc_pkg::entry_t mem_q [CAPACITY];
  eglsc_pkg::entry_t rd_data_q;
  eglsc_pkg::entry_t mem_wd;
  logic              mem_we;
  logic [AW-1:0]     mem_wa;
  logic [AW-1:0]     rd_addr;

  eglsc_pkg::state_e state_q, state_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          pend_q, pend_d;
  logic [AW-1:0] pos_q, pos_d;
  logic          found_q, found_d;
  logic [AW-1:0] found_idx_q, found_idx_d;
  logic          best_vld_q, best_vld_d;
  logic [AW-1:0] best_idx_q, best_idx_d;
  logic [63:0]   best_age_q, best_age_d;
  logic          free_vld_q, free_vld_d;
  logic [AW-1:0] free_idx_q, free_idx_d;
  logic [CW-1:0] guard_q, guard_d;
  logic [CW-1:0] resident_q, resident_d;
  logic [CW-1:0] evicted_q, evicted_d;
  logic [63:0]   age_clock_q, age_clock_d;
  logic [31:0]   idle_mark_q, idle_mark_d;
  logic [31:0]   claimed_q, claimed_d;
  logic          claim_en_q, claim_en_d;
  logic [31:0]   claimant_q, claimant_d;
  logic [31:0]   prefix_q, prefix_d;
  logic [KW-1:0] target_q, target_d;
  logic          hit_q, hit_d;
  logic [AW-1:0] slot_q, slot_d;
  logic          full_q, full_d;
  logic          rv_q, rv_d;
  logic [6:0]    budget_q, budget_d;
  logic [31:0]   layout_q, layout_d;
  logic [7:0]    set_q, set_d;
  logic [1:0]    flags_q, flags_d;
  logic [63:0]   hash_q, hash_d;
  logic [31:0]   newest_q, newest_d;

  logic          issue, scan_done, elig, cfg_wr;
  logic [31:0]   idle_new;
  logic [KW-1:0] res_ext;
  eglsc_pkg::entry_t d;

  assign cfg_wr = psel && penable && pwrite
                  && (eglsc_pkg::reg_idx_e'(paddr[2]) == eglsc_pkg::REG_BUDGET);
  assign pready = 1'b1;
  assign prdata = (eglsc_pkg::reg_idx_e'(paddr[2]) == eglsc_pkg::REG_BUDGET)
                  ? {25'd0, budget_q} : 32'd0;

  assign busy             = (state_q != eglsc_pkg::S_IDLE);
  assign result_valid_o   = rv_q;
  assign hit_o            = hit_q;
  assign slot_o           = 6'(slot_q);
  assign table_full_o     = full_q;
  assign evicted_count_o  = 7'(evicted_q);
  assign resident_count_o = 7'(resident_q);
  assign guarded_count_o  = 7'(guard_q);

  assign issue     = (cnt_q < CAP);
  assign scan_done = (cnt_q == CAP) && !pend_q;
  assign rd_addr   = issue ? cnt_q[AW-1:0] : '0;
  assign d         = rd_data_q;
  assign elig      = (d.epoch != 32'd0) && (d.epoch <= prefix_q);
  assign idle_new  = (newest_epoch_i > idle_mark_q) ? newest_epoch_i : idle_mark_q;
  assign res_ext   = KW'(resident_q);

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    pend_d      = 1'b0;
    pos_d       = pos_q;
    found_d     = found_q;
    found_idx_d = found_idx_q;
    best_vld_d  = best_vld_q;
    best_idx_d  = best_idx_q;
    best_age_d  = best_age_q;
    free_vld_d  = free_vld_q;
    free_idx_d  = free_idx_q;
    guard_d     = guard_q;
    resident_d  = resident_q;
    evicted_d   = evicted_q;
    age_clock_d = age_clock_q;
    idle_mark_d = idle_mark_q;
    claimed_d   = claimed_q;
    claim_en_d  = claim_en_q;
    claimant_d  = claimant_q;
    prefix_d    = prefix_q;
    target_d    = target_q;
    hit_d       = hit_q;
    slot_d      = slot_q;
    full_d      = full_q;
    rv_d        = 1'b0;
    budget_d    = cfg_wr ? pwdata[6:0] : budget_q;
    layout_d    = layout_q;
    set_d       = set_q;
    flags_d     = flags_q;
    hash_d      = hash_q;
    newest_d    = newest_q;
    mem_we      = 1'b0;
    mem_wa      = pos_q;
    mem_wd      = d;

    if (state_q == eglsc_pkg::S_MATCH || state_q == eglsc_pkg::S_EVSCAN
        || state_q == eglsc_pkg::S_FREE || state_q == eglsc_pkg::S_GUARD) begin
      pend_d = issue;
      pos_d  = cnt_q[AW-1:0];
      if (issue) begin
        cnt_d = cnt_q + 1'b1;
      end
    end

    case (state_q)
      eglsc_pkg::S_CLEAR: begin
        if (cnt_q == CAP) begin
          state_d = eglsc_pkg::S_IDLE;
        end else begin
          mem_we = 1'b1;
          mem_wa = cnt_q[AW-1:0];
          mem_wd = '0;
          cnt_d  = cnt_q + 1'b1;
        end
      end
      eglsc_pkg::S_IDLE: begin
        if (start) begin
          layout_d  = layout_id_i;
          set_d     = set_number_i;
          flags_d   = {dynamic_storage_i, dynamic_uniform_i};
          hash_d    = content_hash_i;
          newest_d  = newest_epoch_i;
          hit_d     = 1'b0;
          slot_d    = '0;
          full_d    = 1'b0;
          evicted_d = '0;
          found_d   = 1'b0;
          guard_d   = '0;
          cnt_d     = '0;
          if (action_i) begin
            idle_mark_d = idle_new;
            prefix_d = (completed_epoch_i > idle_new) ? completed_epoch_i : idle_new;
            state_d  = eglsc_pkg::S_GUARD;
          end else begin
            prefix_d = (completed_epoch_i > idle_mark_q) ? completed_epoch_i : idle_mark_q;
            claim_en_d = (newest_epoch_i > claimed_q);
            claimant_d = claimed_q + 32'd1;
            if (newest_epoch_i > claimed_q) begin
              claimed_d = newest_epoch_i;
            end
            state_d = eglsc_pkg::S_MATCH;
          end
        end
      end
      eglsc_pkg::S_MATCH: begin
        if (pend_q) begin
          if (d.valid && d.epoch == 32'd0 && claim_en_q) begin
            mem_we       = 1'b1;
            mem_wd.epoch = claimant_q;
          end
          if (!found_q && d.valid && d.layout == layout_q && d.set == set_q
              && d.flags == flags_q && d.hash == hash_q) begin
            found_d     = 1'b1;
            found_idx_d = pos_q;
          end
        end
        if (scan_done) begin
          if (found_q) begin
            age_clock_d = age_clock_q + 64'd1;
            mem_we      = 1'b1;
            mem_wa      = found_idx_q;
            mem_wd      = {1'b1, layout_q, set_q, flags_q, hash_q, newest_q,
                           age_clock_q + 64'd1};
            hit_d       = 1'b1;
            slot_d      = found_idx_q;
            target_d    = KW'(budget_q);
          end else begin
            target_d = (budget_q != 7'd0) ? KW'(budget_q - 7'd1) : '0;
          end
          state_d = eglsc_pkg::S_EVCHK;
        end
      end
      eglsc_pkg::S_EVCHK: begin
        cnt_d      = '0;
        best_vld_d = 1'b0;
        free_vld_d = 1'b0;
        if (res_ext > target_q) begin
          state_d = eglsc_pkg::S_EVSCAN;
        end else if (found_q) begin
          state_d = eglsc_pkg::S_GUARD;
        end else begin
          state_d = eglsc_pkg::S_FREE;
        end
      end
      eglsc_pkg::S_EVSCAN: begin
        if (pend_q && d.valid && elig && !(found_q && pos_q == found_idx_q)
            && (!best_vld_q || d.age < best_age_q)) begin
          best_vld_d = 1'b1;
          best_idx_d = pos_q;
          best_age_d = d.age;
        end
        if (scan_done) begin
          cnt_d = '0;
          if (best_vld_q) begin
            mem_we     = 1'b1;
            mem_wa     = best_idx_q;
            mem_wd     = '0;
            resident_d = resident_q - 1'b1;
            evicted_d  = evicted_q + 1'b1;
            state_d    = eglsc_pkg::S_EVCHK;
          end else if (found_q) begin
            state_d = eglsc_pkg::S_GUARD;
          end else begin
            state_d = eglsc_pkg::S_FREE;
          end
        end
      end
      eglsc_pkg::S_FREE: begin
        if (pend_q && !d.valid && !free_vld_q) begin
          free_vld_d = 1'b1;
          free_idx_d = pos_q;
        end
        if (scan_done) begin
          cnt_d = '0;
          if (free_vld_q) begin
            age_clock_d = age_clock_q + 64'd1;
            mem_we      = 1'b1;
            mem_wa      = free_idx_q;
            mem_wd      = {1'b1, layout_q, set_q, flags_q, hash_q, newest_q,
                           age_clock_q + 64'd1};
            slot_d      = free_idx_q;
            resident_d  = resident_q + 1'b1;
          end else begin
            full_d = 1'b1;
          end
          state_d = eglsc_pkg::S_GUARD;
        end
      end
      eglsc_pkg::S_GUARD: begin
        if (pend_q && d.valid && !elig) begin
          guard_d = guard_q + 1'b1;
        end
        if (scan_done) begin
          rv_d    = 1'b1;
          state_d = eglsc_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = eglsc_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_wa] <= mem_wd;
    end
    rd_data_q <= mem_q[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= eglsc_pkg::S_CLEAR;
      cnt_q       <= '0;
      pend_q      <= 1'b0;
      pos_q       <= '0;
      found_q     <= 1'b0;
      found_idx_q <= '0;
      best_vld_q  <= 1'b0;
      best_idx_q  <= '0;
      best_age_q  <= '0;
      free_vld_q  <= 1'b0;
      free_idx_q  <= '0;
      guard_q     <= '0;
      resident_q  <= '0;
      evicted_q   <= '0;
      age_clock_q <= '0;
      idle_mark_q <= '0;
      claimed_q   <= '0;
      claim_en_q  <= 1'b0;
      claimant_q  <= '0;
      prefix_q    <= '0;
      target_q    <= '0;
      hit_q       <= 1'b0;
      slot_q      <= '0;
      full_q      <= 1'b0;
      rv_q        <= 1'b0;
      budget_q    <= eglsc_pkg::BUDGET_RESET;
      layout_q    <= '0;
      set_q       <= '0;
      flags_q     <= '0;
      hash_q      <= '0;
      newest_q    <= '0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      pend_q      <= pend_d;
      pos_q       <= pos_d;
      found_q     <= found_d;
      found_idx_q <= found_idx_d;
      best_vld_q  <= best_vld_d;
      best_idx_q  <= best_idx_d;
      best_age_q  <= best_age_d;
      free_vld_q  <= free_vld_d;
      free_idx_q  <= free_idx_d;
      guard_q     <= guard_d;
      resident_q  <= resident_d;
      evicted_q   <= evicted_d;
      age_clock_q <= age_clock_d;
      idle_mark_q <= idle_mark_d;
      claimed_q   <= claimed_d;
      claim_en_q  <= claim_en_d;
      claimant_q  <= claimant_d;
      prefix_q    <= prefix_d;
      target_q    <= target_d;
      hit_q       <= hit_d;
      slot_q      <= slot_d;
      full_q      <= full_d;
      rv_q        <= rv_d;
      budget_q    <= budget_d;
      layout_q    <= layout_d;
      set_q       <= set_d;
      flags_q     <= flags_d;
      hash_q      <= hash_d;
      newest_q    <= newest_d;
    end
  end

endmodule
